// ===== rtl/agb_pkg.sv =====
// ----------------------------------------------------------------------------
// agb_pkg
// Widths, register indexes, reset values and stage types shared by the
// afterglow pixel blend pipeline.
// ----------------------------------------------------------------------------
package agb_pkg;

  localparam int PIX_W      = 8;   // pixel coordinate and color channel
  localparam int DOT_X_W    = 10;  // signed dot column
  localparam int DOT_Y_W    = 8;
  localparam int BLUR_W     = 6;
  localparam int INT_W      = 9;   // intensity, 0..511
  localparam int DX_W       = 10;  // |pix_x - dot_x|, up to 767
  localparam int DY_W       = 8;
  localparam int DX2_W      = 2 * DX_W;
  localparam int DY2_W      = 2 * DY_W;
  localparam int DEN_W      = 20;  // r2 + bf - 1 stays below 2**20
  localparam int NUM_W      = 15;  // peak * bf, up to 32193
  localparam int REM_W      = NUM_W;
  localparam int QUO_W      = INT_W;  // off-center quotient never exceeds peak
  localparam int DIV_CMP_W  = DEN_W + QUO_W - 1;
  localparam int DOTC_W     = 7;   // floor(dot * 15 / 100) <= 76

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_DOT_X          = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DOT_Y          = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BLUR_WIDTH     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_INTENSITY = CFG_IDX_W'(3);

  localparam logic signed [DOT_X_W-1:0] DOT_X_RST = '0;
  localparam logic [DOT_Y_W-1:0]        DOT_Y_RST = '0;
  localparam logic [BLUR_W-1:0]         BLUR_RST  = BLUR_W'(8);
  localparam logic [INT_W-1:0]          PEAK_RST  = INT_W'(400);

  localparam logic [INT_W-1:0] INT_MAX    = '1;
  localparam logic [7:0]       FADE_NUM   = 8'd250;   // fade by 250/256
  localparam logic [7:0]       DIV5_RECIP = 8'd205;   // 205/1024 ~ 1/5
  localparam int               DIV5_SHIFT = 10;

  typedef struct packed {
    logic signed [DOT_X_W-1:0] dot_x;
    logic [DOT_Y_W-1:0]        dot_y;
    logic [BLUR_W-1:0]         blur_width;
    logic [INT_W-1:0]          peak_intensity;
  } agb_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix_x;
    logic [PIX_W-1:0] pix_y;
    logic [PIX_W-1:0] old_red;
    logic [PIX_W-1:0] old_green;
  } pix_in_t;

  // divider stage word: partial remainder, divisor and quotient so far
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             r2_zero;
    logic             den_zero;
    logic [INT_W-1:0] fade;
  } div_stage_t;

  typedef struct packed {
    logic [PIX_W-1:0] new_red;
    logic [PIX_W-1:0] new_green;
    logic [PIX_W-1:0] new_blue;
  } rgb_t;

endpackage

// ===== rtl/agb_in_if.sv =====
// ----------------------------------------------------------------------------
// agb_in_if
// Pixel item channel: coordinates and previous red and green values.
// ----------------------------------------------------------------------------
interface agb_in_if
  import agb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pix_x;
  logic [PIX_W-1:0] pix_y;
  logic [PIX_W-1:0] old_red;
  logic [PIX_W-1:0] old_green;

  modport source (output valid, output pix_x, output pix_y, output old_red,
                  output old_green, input ready);
  modport sink   (input valid, input pix_x, input pix_y, input old_red,
                  input old_green, output ready);
endinterface

// ===== rtl/agb_out_if.sv =====
// ----------------------------------------------------------------------------
// agb_out_if
// Result item channel: new red, green and blue values of one pixel.
// ----------------------------------------------------------------------------
interface agb_out_if
  import agb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] new_red;
  logic [PIX_W-1:0] new_green;
  logic [PIX_W-1:0] new_blue;

  modport source (output valid, output new_red, output new_green,
                  output new_blue, input ready);
  modport sink   (input valid, input new_red, input new_green,
                  input new_blue, output ready);
endinterface

// ===== rtl/agb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// agb_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface agb_cfg_if
  import agb_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/agb_dist.sv =====
// ----------------------------------------------------------------------------
// agb_dist
// Front end: distance to the dot, old intensity fade, and divider operands.
// Three register stages.
// ----------------------------------------------------------------------------
module agb_dist
  import agb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  agb_cfg_t   cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  pix_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output div_stage_t out_data
);

  typedef struct packed {
    logic [DX_W-1:0]  dx;
    logic [DY_W-1:0]  dy;
    logic [INT_W-1:0] fade;
  } s1_t;

  typedef struct packed {
    logic [DX2_W-1:0] dx2;
    logic [DY2_W-1:0] dy2;
    logic [INT_W-1:0] fade;
  } s2_t;

  logic       v1_r, v2_r, v3_r;
  logic       rdy1, rdy2, rdy3;
  s1_t        s1_r, s1_nxt;
  s2_t        s2_r, s2_nxt;
  div_stage_t s3_r, s3_nxt;

  logic signed [DX_W:0]  dx_s;
  logic signed [DY_W:0]  dy_s;
  logic [INT_W-1:0]      old_int;
  logic [INT_W+7:0]      fade_prod;
  logic [DEN_W-1:0]      r2;
  logic [DEN_W:0]        den_full;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: absolute distances and faded old intensity
  always_comb begin
    dx_s      = $signed({3'b000, in_data.pix_x}) - $signed({cfg.dot_x[DOT_X_W-1], cfg.dot_x});
    dy_s      = $signed({1'b0, in_data.pix_y}) - $signed({1'b0, cfg.dot_y});
    old_int   = (in_data.old_red != '0) ? {1'b1, in_data.old_red}
                                        : {1'b0, in_data.old_green};
    fade_prod = old_int * FADE_NUM;
    s1_nxt.dx   = dx_s[DX_W] ? DX_W'(-dx_s) : DX_W'(dx_s);
    s1_nxt.dy   = dy_s[DY_W] ? DY_W'(-dy_s) : DY_W'(dy_s);
    s1_nxt.fade = fade_prod[INT_W+7:8];
  end

  // stage 2: squares
  always_comb begin
    s2_nxt.dx2  = s1_r.dx * s1_r.dx;
    s2_nxt.dy2  = s1_r.dy * s1_r.dy;
    s2_nxt.fade = s1_r.fade;
  end

  // stage 3: r2, divisor and numerator
  always_comb begin
    r2       = DEN_W'(s2_r.dx2) + DEN_W'(s2_r.dy2);
    den_full = {1'b0, r2} + (DEN_W+1)'(cfg.blur_width) - (DEN_W+1)'(1);
    s3_nxt.rem      = NUM_W'(cfg.peak_intensity) * NUM_W'(cfg.blur_width);
    s3_nxt.den      = den_full[DEN_W-1:0];
    s3_nxt.quo      = '0;
    s3_nxt.r2_zero  = (r2 == '0);
    s3_nxt.den_zero = (r2 != '0) && (den_full == '0);
    s3_nxt.fade     = s2_r.fade;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r)     s2_r <= s2_nxt;
    if (rdy3 && v2_r)     s3_r <= s3_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule

// ===== rtl/agb_div.sv =====
// ----------------------------------------------------------------------------
// agb_div
// Pipelined restoring divider, one quotient bit per register stage, most
// significant bit first.
// ----------------------------------------------------------------------------
module agb_div
  import agb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  div_stage_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output div_stage_t out_data
);

  logic       v_r  [QUO_W];
  div_stage_t st_r [QUO_W];
  logic [QUO_W:0] rdy;

  assign rdy[QUO_W] = out_ready;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int BIT = QUO_W - 1 - k;

    div_stage_t           src;
    logic                 src_v;
    div_stage_t           stage_nxt;
    logic [DIV_CMP_W-1:0] trial;

    if (k == 0) begin : g_first
      assign src   = in_data;
      assign src_v = in_valid;
    end else begin : g_rest
      assign src   = st_r[k-1];
      assign src_v = v_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    // subtract the shifted divisor where it fits
    always_comb begin
      stage_nxt = src;
      trial     = DIV_CMP_W'(src.den) << BIT;
      if (DIV_CMP_W'(src.rem) >= trial) begin
        stage_nxt.rem      = src.rem - REM_W'(trial);
        stage_nxt.quo[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && src_v) st_r[k] <= stage_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[QUO_W-1];
  assign out_data  = st_r[QUO_W-1];

endmodule

// ===== rtl/agb_map.sv =====
// ----------------------------------------------------------------------------
// agb_map
// Back end: dot term scaling by 0.15, sum with the faded intensity, clamp and
// color ramp. The second stage is the output register.
// ----------------------------------------------------------------------------
module agb_map
  import agb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [INT_W-1:0] peak_intensity,
  input  logic             in_valid,
  output logic             in_ready,
  input  div_stage_t       in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rgb_t             out_data
);

  typedef struct packed {
    logic [INT_W-1:0]  fade;
    logic [DOTC_W-1:0] dotc;
  } m1_t;

  logic  v1_r, v2_r;
  logic  rdy1, rdy2;
  m1_t   m1_r, m1_nxt;
  rgb_t  rgb_r, rgb_nxt;

  logic [INT_W-1:0]    dot;
  logic [INT_W+1:0]    dot3;
  logic [INT_W+7:0]    div5_prod;
  logic [INT_W:0]      sum;
  logic [INT_W-1:0]    inten;

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // dot * 15 / 100 = floor(floor(dot * 3 / 4) / 5), exact for dot <= 511
  always_comb begin
    if (in_data.r2_zero) begin
      dot = peak_intensity;
    end else if (in_data.den_zero) begin
      dot = '0;
    end else begin
      dot = in_data.quo;
    end
    dot3        = (INT_W+2)'(dot) * (INT_W+2)'(3);
    div5_prod   = (INT_W+8)'(dot3[INT_W+1:2]) * (INT_W+8)'(DIV5_RECIP);
    m1_nxt.fade = in_data.fade;
    m1_nxt.dotc = DOTC_W'(div5_prod >> DIV5_SHIFT);
  end

  always_comb begin
    sum   = (INT_W+1)'(m1_r.fade) + (INT_W+1)'(m1_r.dotc);
    inten = sum[INT_W] ? INT_MAX : sum[INT_W-1:0];
    if (inten[INT_W-1]) begin
      rgb_nxt.new_red   = inten[PIX_W-1:0];
      rgb_nxt.new_green = '1;
    end else begin
      rgb_nxt.new_red   = '0;
      rgb_nxt.new_green = inten[PIX_W-1:0];
    end
    rgb_nxt.new_blue = inten[INT_W-1:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) m1_r  <= m1_nxt;
    if (rdy2 && v1_r)     rgb_r <= rgb_nxt;
  end

  assign out_valid = v2_r;
  assign out_data  = rgb_r;

endmodule

// ===== rtl/afterglow_pixel_blend.sv =====
// ----------------------------------------------------------------------------
// afterglow_pixel_blend
// Fades one LED matrix pixel and adds the glow of a configurable dot.
// ----------------------------------------------------------------------------
// One pixel item enters per clock while the output is not stalled: three
// stages compute the distance, the fade and the divider operands, nine stages
// form the 9-bit quotient of the dot glow one bit per stage, and two stages
// scale, sum and map the intensity to a color, the last being the output
// register. Every stage holds its own valid bit, so a stalled output only
// holds the items behind it until a bubble is filled, and input is still taken
// while bubbles remain. Register writes are taken in any cycle and must only
// be issued while no item is in flight.
module afterglow_pixel_blend
  import agb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  agb_in_if.sink      in_ch,
  agb_out_if.source   out_ch,
  agb_cfg_if.sink     cfg_ch
);

  agb_cfg_t   cfg_r;
  pix_in_t    pix_in;
  div_stage_t dist_data, div_data;
  logic       dist_valid, dist_ready;
  logic       div_valid, div_ready;
  rgb_t       rgb_out;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_x          <= DOT_X_RST;
      cfg_r.dot_y          <= DOT_Y_RST;
      cfg_r.blur_width     <= BLUR_RST;
      cfg_r.peak_intensity <= PEAK_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DOT_X:          cfg_r.dot_x          <= $signed(cfg_ch.data[DOT_X_W-1:0]);
        REG_DOT_Y:          cfg_r.dot_y          <= cfg_ch.data[DOT_Y_W-1:0];
        REG_BLUR_WIDTH:     cfg_r.blur_width     <= cfg_ch.data[BLUR_W-1:0];
        REG_PEAK_INTENSITY: cfg_r.peak_intensity <= cfg_ch.data[INT_W-1:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  assign pix_in.pix_x     = in_ch.pix_x;
  assign pix_in.pix_y     = in_ch.pix_y;
  assign pix_in.old_red   = in_ch.old_red;
  assign pix_in.old_green = in_ch.old_green;

  agb_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (pix_in),
    .out_valid (dist_valid),
    .out_ready (dist_ready),
    .out_data  (dist_data)
  );

  agb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dist_valid),
    .in_ready  (dist_ready),
    .in_data   (dist_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  agb_map u_map (
    .clk            (clk),
    .rst_n          (rst_n),
    .peak_intensity (cfg_r.peak_intensity),
    .in_valid       (div_valid),
    .in_ready       (div_ready),
    .in_data        (div_data),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_data       (rgb_out)
  );

  assign out_ch.new_red   = rgb_out.new_red;
  assign out_ch.new_green = rgb_out.new_green;
  assign out_ch.new_blue  = rgb_out.new_blue;

endmodule

// ===== rtl/agb_checker.sv =====
// ----------------------------------------------------------------------------
// agb_checker
// Port-level checks on the result channel of the afterglow pixel blend.
// ----------------------------------------------------------------------------
module agb_checker
  import agb_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] new_red,
  input logic [PIX_W-1:0] new_green,
  input logic [PIX_W-1:0] new_blue
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(new_red) && $stable(new_green)
                                && $stable(new_blue))
    else $error("result changed while stalled");

  // above 255 the ramp saturates green and blue tracks red
  a_red_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && new_red != '0 |-> new_green == '1 && new_blue == {1'b1, new_red[PIX_W-1:1]})
    else $error("red ramp inconsistent");

  // below 255 there is no red and blue is half of green
  a_green_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && new_green != '1 |-> new_red == '0 && new_blue == {1'b0, new_green[PIX_W-1:1]})
    else $error("green ramp inconsistent");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind afterglow_pixel_blend agb_checker u_agb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .new_red   (out_ch.new_red),
  .new_green (out_ch.new_green),
  .new_blue  (out_ch.new_blue)
);
